// File: rtl/dpbrm_pkg.sv
// Shared types, widths, register indexes and reset values of the depth back-projection block.
package dpbrm_pkg;

    localparam int DEPTH_W        = 16;
    localparam int COORD_W        = 12;
    localparam int PRIN_W         = 16;
    localparam int INV_W          = 24;
    localparam int INV_HALF       = INV_W / 2;
    localparam int BOX_W          = 32;
    localparam int BOX_HALF       = BOX_W / 2;
    localparam int LIMIT_W        = 16;
    localparam int POINT_W        = 32;
    localparam int FRAC_BITS      = 28;
    localparam int CFG_IDX_W      = 3;
    localparam int CFG_DATA_W     = 32;

    localparam int COORD_BITS_DEF = 12;
    localparam int DEPTH_BITS_DEF = 16;

    localparam logic [CFG_IDX_W-1:0] CFG_PRINCIPAL_X = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_PRINCIPAL_Y = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_INV_FOCAL_X = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_INV_FOCAL_Y = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_BOX_ORIGIN  = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_BOX_SIZE    = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_NEAR_LIMIT  = 3'd6;

    localparam logic [PRIN_W-1:0]  PRINCIPAL_X_RST = 16'd32768;
    localparam logic [PRIN_W-1:0]  PRINCIPAL_Y_RST = 16'd24576;
    localparam logic [INV_W-1:0]   INV_FOCAL_RST   = 24'd31956;
    localparam logic [BOX_W-1:0]   BOX_ORIGIN_RST  = 32'd0;
    localparam logic [BOX_W-1:0]   BOX_SIZE_RST    = 32'd0;
    localparam logic [LIMIT_W-1:0] NEAR_LIMIT_RST  = 16'd2000;

    typedef struct packed {
        logic [DEPTH_W-1:0] depth_mm;
        logic [COORD_W-1:0] column;
        logic [COORD_W-1:0] row;
    } pixel_t;

    typedef struct packed {
        logic signed [POINT_W-1:0] point_x;
        logic signed [POINT_W-1:0] point_y;
        logic [DEPTH_W-1:0]        point_z;
        logic                      valid_res;
        logic                      in_mask;
        logic                      is_center;
    } point_t;

endpackage

// File: rtl/depth_pixel_backproject_roi_mask.sv
// Pinhole back-projection of a depth pixel stream with box and near-limit mask and box-centre flag.
//
// One pixel request is taken every clock while pixel_stall is low, and each gives one
// point request. The three register stages are: offset and depth multiply, the split
// multiply by the reciprocal focal length, then rounding and saturation into the output
// register. Stall from the point side fills empty stages before it reaches the pixel
// side. Registers may only be written while no request is in flight.
module depth_pixel_backproject_roi_mask
    import dpbrm_pkg::*;
#(
    parameter int COORD_BITS = COORD_BITS_DEF,
    parameter int DEPTH_BITS = DEPTH_BITS_DEF
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_idx,
    input  logic [CFG_DATA_W-1:0] cfg_wdata,
    input  logic                  pixel_valid,
    output logic                  pixel_stall,
    input  pixel_t                pixel,
    output logic                  point_valid,
    input  logic                  point_stall,
    output point_t                point
);

    localparam int SCALED_W = COORD_BITS + 4;
    localparam int DIFF_W   = (SCALED_W > PRIN_W) ? SCALED_W : PRIN_W;
    localparam int M_W      = DIFF_W + DEPTH_BITS;
    localparam int P_W      = M_W + INV_HALF;
    localparam int PROD_W   = M_W + INV_W;
    localparam int SUM_W    = PROD_W + 1;
    localparam int MAG_W    = SUM_W - FRAC_BITS;
    localparam int SAT_W    = (MAG_W > POINT_W + 1) ? MAG_W : POINT_W + 1;
    localparam int BOXC_W   = BOX_HALF + 1;

    function automatic logic [DIFF_W:0] axis_offset(
        input logic [COORD_BITS-1:0] pix,
        input logic [PRIN_W-1:0]     principal
    );
        logic [DIFF_W:0] sc;
        logic [DIFF_W:0] pr;
        logic            neg;
        logic [DIFF_W:0] d;
        sc  = (DIFF_W + 1)'({pix, 4'b0000});
        pr  = (DIFF_W + 1)'(principal);
        neg = sc < pr;
        d   = neg ? (pr - sc) : (sc - pr);
        return {neg, d[DIFF_W-1:0]};
    endfunction

    function automatic logic [POINT_W-1:0] round_sat(
        input logic [P_W-1:0] p_lo,
        input logic [P_W-1:0] p_hi,
        input logic           neg
    );
        logic [SUM_W-1:0]   sum;
        logic [SAT_W-1:0]   mag;
        logic [POINT_W-1:0] lim;
        sum = SUM_W'(p_lo) + (SUM_W'(p_hi) << INV_HALF) + (SUM_W'(1) << (FRAC_BITS - 1));
        mag = SAT_W'(sum[SUM_W-1:FRAC_BITS]);
        if (!neg)
        begin
            lim = (mag > SAT_W'(32'h7FFF_FFFF)) ? 32'h7FFF_FFFF : mag[POINT_W-1:0];
            return lim;
        end
        lim = (mag > SAT_W'(32'h8000_0000)) ? 32'h8000_0000 : mag[POINT_W-1:0];
        return ~lim + 32'd1;
    endfunction

    logic [PRIN_W-1:0]  principal_x_reg;
    logic [PRIN_W-1:0]  principal_y_reg;
    logic [INV_W-1:0]   inv_focal_x_reg;
    logic [INV_W-1:0]   inv_focal_y_reg;
    logic [BOX_W-1:0]   box_origin_reg;
    logic [BOX_W-1:0]   box_size_reg;
    logic [LIMIT_W-1:0] near_limit_reg;

    logic adv1;
    logic adv2;
    logic adv3;
    logic s1_v_reg;
    logic s2_v_reg;
    logic s3_v_reg;

    logic [M_W-1:0]        s1_mx_reg, s1_mx_next;
    logic [M_W-1:0]        s1_my_reg, s1_my_next;
    logic                  s1_negx_reg, s1_negx_next;
    logic                  s1_negy_reg, s1_negy_next;
    logic [DEPTH_BITS-1:0] s1_depth_reg, s1_depth_next;
    logic                  s1_valid_reg, s1_valid_next;
    logic                  s1_mask_reg, s1_mask_next;
    logic                  s1_centre_reg, s1_centre_next;

    logic [P_W-1:0]        s2_plx_reg, s2_phx_reg, s2_ply_reg, s2_phy_reg;
    logic                  s2_negx_reg, s2_negy_reg;
    logic [DEPTH_BITS-1:0] s2_depth_reg;
    logic                  s2_valid_reg, s2_mask_reg, s2_centre_reg;

    point_t                point_reg, point_next;

    logic [DEPTH_BITS-1:0] depth;
    logic [COORD_BITS-1:0] col;
    logic [COORD_BITS-1:0] row;
    logic [DIFF_W:0]       off_x;
    logic [DIFF_W:0]       off_y;
    logic [BOXC_W-1:0]     col_e, row_e, left_e, top_e, wid_e, hgt_e;
    logic                  in_box;

    // Configuration
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            principal_x_reg <= PRINCIPAL_X_RST;
            principal_y_reg <= PRINCIPAL_Y_RST;
            inv_focal_x_reg <= INV_FOCAL_RST;
            inv_focal_y_reg <= INV_FOCAL_RST;
            box_origin_reg  <= BOX_ORIGIN_RST;
            box_size_reg    <= BOX_SIZE_RST;
            near_limit_reg  <= NEAR_LIMIT_RST;
        end
        else if (cfg_we)
        begin
            unique case (cfg_idx)
                CFG_PRINCIPAL_X: principal_x_reg <= cfg_wdata[PRIN_W-1:0];
                CFG_PRINCIPAL_Y: principal_y_reg <= cfg_wdata[PRIN_W-1:0];
                CFG_INV_FOCAL_X: inv_focal_x_reg <= cfg_wdata[INV_W-1:0];
                CFG_INV_FOCAL_Y: inv_focal_y_reg <= cfg_wdata[INV_W-1:0];
                CFG_BOX_ORIGIN:  box_origin_reg  <= cfg_wdata[BOX_W-1:0];
                CFG_BOX_SIZE:    box_size_reg    <= cfg_wdata[BOX_W-1:0];
                CFG_NEAR_LIMIT:  near_limit_reg  <= cfg_wdata[LIMIT_W-1:0];
                default:         ;
            endcase
        end
    end

    // Pipeline control: advance a stage when it is empty or the next one advances
    assign adv3        = !s3_v_reg || !point_stall;
    assign adv2        = !s2_v_reg || adv3;
    assign adv1        = !s1_v_reg || adv2;
    assign pixel_stall = !adv1;
    assign point_valid = s3_v_reg;
    assign point       = point_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_v_reg <= 1'b0;
            s2_v_reg <= 1'b0;
            s3_v_reg <= 1'b0;
        end
        else
        begin
            if (adv1)
            begin
                s1_v_reg <= pixel_valid;
            end
            if (adv2)
            begin
                s2_v_reg <= s1_v_reg;
            end
            if (adv3)
            begin
                s3_v_reg <= s2_v_reg;
            end
        end
    end

    // Stage 1: offsets, depth multiply, box tests
    always_comb
    begin
        depth  = DEPTH_BITS'(pixel.depth_mm);
        col    = COORD_BITS'(pixel.column);
        row    = COORD_BITS'(pixel.row);
        off_x  = axis_offset(col, principal_x_reg);
        off_y  = axis_offset(row, principal_y_reg);
        col_e  = BOXC_W'(col);
        row_e  = BOXC_W'(row);
        left_e = BOXC_W'(box_origin_reg[BOX_HALF-1:0]);
        top_e  = BOXC_W'(box_origin_reg[BOX_W-1:BOX_HALF]);
        wid_e  = BOXC_W'(box_size_reg[BOX_HALF-1:0]);
        hgt_e  = BOXC_W'(box_size_reg[BOX_W-1:BOX_HALF]);
        in_box = (col_e >= left_e) && (col_e < left_e + wid_e)
              && (row_e >= top_e) && (row_e < top_e + hgt_e);

        s1_negx_next   = off_x[DIFF_W];
        s1_negy_next   = off_y[DIFF_W];
        s1_mx_next     = M_W'(off_x[DIFF_W-1:0]) * M_W'(depth);
        s1_my_next     = M_W'(off_y[DIFF_W-1:0]) * M_W'(depth);
        s1_depth_next  = depth;
        s1_valid_next  = depth != '0;
        s1_mask_next   = in_box && (depth != '0) && (LIMIT_W'(depth) < near_limit_reg);
        s1_centre_next = in_box && (col_e == left_e + (wid_e >> 1))
                      && (row_e == top_e + (hgt_e >> 1));
    end

    always_ff @(posedge clk)
    begin
        if (adv1)
        begin
            s1_mx_reg     <= s1_mx_next;
            s1_my_reg     <= s1_my_next;
            s1_negx_reg   <= s1_negx_next;
            s1_negy_reg   <= s1_negy_next;
            s1_depth_reg  <= s1_depth_next;
            s1_valid_reg  <= s1_valid_next;
            s1_mask_reg   <= s1_mask_next;
            s1_centre_reg <= s1_centre_next;
        end
    end

    // Stage 2: multiply by the reciprocal focal length in two halves
    always_ff @(posedge clk)
    begin
        if (adv2)
        begin
            s2_plx_reg    <= P_W'(s1_mx_reg) * P_W'(inv_focal_x_reg[INV_HALF-1:0]);
            s2_phx_reg    <= P_W'(s1_mx_reg) * P_W'(inv_focal_x_reg[INV_W-1:INV_HALF]);
            s2_ply_reg    <= P_W'(s1_my_reg) * P_W'(inv_focal_y_reg[INV_HALF-1:0]);
            s2_phy_reg    <= P_W'(s1_my_reg) * P_W'(inv_focal_y_reg[INV_W-1:INV_HALF]);
            s2_negx_reg   <= s1_negx_reg;
            s2_negy_reg   <= s1_negy_reg;
            s2_depth_reg  <= s1_depth_reg;
            s2_valid_reg  <= s1_valid_reg;
            s2_mask_reg   <= s1_mask_reg;
            s2_centre_reg <= s1_centre_reg;
        end
    end

    // Stage 3: round, saturate, zero invalid points
    always_comb
    begin
        point_next.point_x   = s2_valid_reg
                             ? round_sat(s2_plx_reg, s2_phx_reg, s2_negx_reg) : '0;
        point_next.point_y   = s2_valid_reg
                             ? round_sat(s2_ply_reg, s2_phy_reg, s2_negy_reg) : '0;
        point_next.point_z   = DEPTH_W'(s2_depth_reg);
        point_next.valid_res = s2_valid_reg;
        point_next.in_mask   = s2_mask_reg;
        point_next.is_center = s2_centre_reg;
    end

    always_ff @(posedge clk)
    begin
        if (adv3)
        begin
            point_reg <= point_next;
        end
    end

    a_full_stall: assert property (@(posedge clk) disable iff (!rst_n)
        (s1_v_reg && s2_v_reg && s3_v_reg && point_stall) |-> pixel_stall)
        else $error("pipeline full and stalled but pixel side not stalled");

    a_accept_enters: assert property (@(posedge clk) disable iff (!rst_n)
        (pixel_valid && !pixel_stall) |=> s1_v_reg)
        else $error("accepted pixel did not enter first stage");

    a_invalid_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (point_valid && !point.valid_res) |->
        (point.point_x == '0 && point.point_y == '0 && point.point_z == '0))
        else $error("invalid point carries nonzero coordinates");

    a_mask_valid: assert property (@(posedge clk) disable iff (!rst_n)
        (point_valid && point.in_mask) |-> point.valid_res)
        else $error("masked point without valid depth");

endmodule
